// ----- rtl/gpio_rb_pkg.sv -----
// Package: shared types, widths and register offsets of the GPIO register block.
`default_nettype none
package gpio_rb_pkg;

  // Pin count and field widths
  localparam int unsigned NumPins     = 54;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned OffsetWidth = 6;
  localparam int unsigned SelWords    = 6;
  localparam int unsigned PinsPerSel  = 10;
  localparam int unsigned SelBits     = 3;
  localparam int unsigned SelWidth    = PinsPerSel * SelBits;
  localparam int unsigned SelPins     = SelWords * PinsPerSel;
  localparam int unsigned PullWidth   = 2;
  localparam int unsigned BankPins    = 32;

  // Access codes
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Register word offsets
  localparam logic [OffsetWidth-1:0] OffSelFirst = 6'd0;
  localparam logic [OffsetWidth-1:0] OffSelLast  = 6'd5;
  localparam logic [OffsetWidth-1:0] OffSet0     = 6'd7;
  localparam logic [OffsetWidth-1:0] OffSet1     = 6'd8;
  localparam logic [OffsetWidth-1:0] OffClr0     = 6'd10;
  localparam logic [OffsetWidth-1:0] OffClr1     = 6'd11;
  localparam logic [OffsetWidth-1:0] OffLev0     = 6'd13;
  localparam logic [OffsetWidth-1:0] OffLev1     = 6'd14;
  localparam logic [OffsetWidth-1:0] OffPullCode = 6'd37;
  localparam logic [OffsetWidth-1:0] OffPullClk0 = 6'd38;
  localparam logic [OffsetWidth-1:0] OffPullClk1 = 6'd39;

  // Function select and pull codes
  localparam logic [SelBits-1:0]   FselOutput = 3'd1;
  localparam logic [PullWidth-1:0] PullDown   = 2'd1;
  localparam logic [PullWidth-1:0] PullUp     = 2'd2;

  // Request beat
  typedef struct packed {
    logic                   opcode;
    logic [OffsetWidth-1:0] word_offset;
    logic [DataWidth-1:0]   write_data;
    logic [NumPins-1:0]     pin_levels_in;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic [NumPins-1:0]   drive_levels;
    logic [NumPins-1:0]   drive_enables;
    logic [NumPins-1:0]   pull_up_enables;
    logic [NumPins-1:0]   pull_down_enables;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/gpio_rb_req_if.sv -----
// Interface: request channel of the GPIO register block.
`default_nettype none
interface gpio_rb_req_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [gpio_rb_pkg::OffsetWidth-1:0] word_offset;
  logic [gpio_rb_pkg::DataWidth-1:0]   write_data;
  logic [gpio_rb_pkg::NumPins-1:0]     pin_levels_in;

  modport source (output valid, opcode, word_offset, write_data, pin_levels_in,
                  input ready);
  modport sink   (input valid, opcode, word_offset, write_data, pin_levels_in,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/gpio_rb_rsp_if.sv -----
// Interface: response channel of the GPIO register block.
`default_nettype none
interface gpio_rb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [gpio_rb_pkg::DataWidth-1:0] read_data;
  logic [gpio_rb_pkg::NumPins-1:0]   drive_levels;
  logic [gpio_rb_pkg::NumPins-1:0]   drive_enables;
  logic [gpio_rb_pkg::NumPins-1:0]   pull_up_enables;
  logic [gpio_rb_pkg::NumPins-1:0]   pull_down_enables;

  modport source (output valid, read_data, drive_levels, drive_enables,
                  pull_up_enables, pull_down_enables, input ready);
  modport sink   (input valid, read_data, drive_levels, drive_enables,
                  pull_up_enables, pull_down_enables, output ready);
endinterface
`default_nettype wire

// ----- rtl/gpio_register_block.sv -----
// Top level: GPIO register block with function select, set/clear latch and pull control.
//
// Each request beat is one 32-bit word access (read or write) and yields exactly one
// response beat carrying the read word (zero on writes) and the pin control vectors
// after the access. A beat is captured in an input register, executed against the
// register state once the result register is free or being drained, and lands in the
// result register, which holds its response until taken. One access is accepted every
// cycle while the response side keeps taking beats. The input register decouples the
// two sides: a new beat is taken while a finished response still waits, as long as the
// input register is empty. Unknown offsets read zero and ignore writes; level words
// read the output latch for pins selected as output and the external level otherwise.
`default_nettype none
module gpio_register_block (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  gpio_rb_req_if.sink         req_i,
  gpio_rb_rsp_if.source       rsp_o
);

  localparam int unsigned NP = gpio_rb_pkg::NumPins;
  localparam int unsigned DW = gpio_rb_pkg::DataWidth;

  // Input stage
  logic               st_valid_q;
  gpio_rb_pkg::req_t  st_q;
  logic               advance;

  // Result stage
  logic               res_valid_q;
  gpio_rb_pkg::rsp_t  res_q, res_d;

  // Architectural state
  logic [gpio_rb_pkg::SelWidth-1:0]  fsel_q [gpio_rb_pkg::SelWords];
  logic [gpio_rb_pkg::SelWidth-1:0]  fsel_d [gpio_rb_pkg::SelWords];
  logic [NP-1:0]                     latch_q, latch_d;
  logic [gpio_rb_pkg::PullWidth-1:0] pcode_q, pcode_d;
  logic [DW-1:0]                     pclk_q [2];
  logic [DW-1:0]                     pclk_d [2];
  logic [gpio_rb_pkg::PullWidth-1:0] pstate_q [NP];
  logic [gpio_rb_pkg::PullWidth-1:0] pstate_d [NP];

  // Access decode helpers
  logic                  wr;
  logic [DW-1:0]         data;
  logic [2*DW-1:0]       bank_wide;
  logic [NP-1:0]         bank_bits;
  logic [NP-1:0]         en_d;
  logic [NP-1:0]         lv;
  logic [2*DW-1:0]       lv_wide;
  logic [DW-1:0]         rd;
  logic                  clk_wr0, clk_wr1;

  // Handshake: execute when the result slot is free or being drained
  assign advance     = st_valid_q && (!res_valid_q || rsp_o.ready);
  assign req_i.ready = !st_valid_q || advance;

  // Capture request beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      st_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      st_q.opcode        <= req_i.opcode;
      st_q.word_offset   <= req_i.word_offset;
      st_q.write_data    <= req_i.write_data;
      st_q.pin_levels_in <= req_i.pin_levels_in;
    end
  end

  assign wr   = (st_q.opcode == gpio_rb_pkg::OpWrite);
  assign data = st_q.write_data;

  // Place a bank word on its pins (bank 1 covers only pins 32 to 53)
  always_comb begin
    if (st_q.word_offset == gpio_rb_pkg::OffSet1 ||
        st_q.word_offset == gpio_rb_pkg::OffClr1) begin
      bank_wide = {data, {DW{1'b0}}};
    end else begin
      bank_wide = {{DW{1'b0}}, data};
    end
    bank_bits = bank_wide[NP-1:0];
  end

  assign clk_wr0 = wr && (st_q.word_offset == gpio_rb_pkg::OffPullClk0);
  assign clk_wr1 = wr && (st_q.word_offset == gpio_rb_pkg::OffPullClk1);

  // Next state of the registers written by this access
  always_comb begin
    fsel_d  = fsel_q;
    latch_d = latch_q;
    pcode_d = pcode_q;
    pclk_d  = pclk_q;
    if (wr) begin
      unique case (st_q.word_offset) inside
        [gpio_rb_pkg::OffSelFirst:gpio_rb_pkg::OffSelLast]: begin
          fsel_d[st_q.word_offset[2:0]] = data[gpio_rb_pkg::SelWidth-1:0];
        end
        gpio_rb_pkg::OffSet0, gpio_rb_pkg::OffSet1: begin
          latch_d = latch_q | bank_bits;
        end
        gpio_rb_pkg::OffClr0, gpio_rb_pkg::OffClr1: begin
          latch_d = latch_q & ~bank_bits;
        end
        gpio_rb_pkg::OffPullCode: begin
          pcode_d = data[gpio_rb_pkg::PullWidth-1:0];
        end
        gpio_rb_pkg::OffPullClk0: begin
          pclk_d[0] = data;
        end
        gpio_rb_pkg::OffPullClk1: begin
          pclk_d[1] = data;
        end
        default: begin
        end
      endcase
    end
  end

  // Clock the current pull code into every pin whose clock bit is set
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      pstate_d[p] = pstate_q[p];
      if ((p < DW && clk_wr0 && data[p % DW]) ||
          (p >= DW && clk_wr1 && data[p % DW])) begin
        pstate_d[p] = pcode_q;
      end
    end
  end

  // Drive enables: pins selected as output, pins without a select word stay inputs
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      if (p < gpio_rb_pkg::SelPins) begin
        en_d[p] = (fsel_d[p / gpio_rb_pkg::PinsPerSel]
                   [(p % gpio_rb_pkg::PinsPerSel) * gpio_rb_pkg::SelBits +:
                    gpio_rb_pkg::SelBits] == gpio_rb_pkg::FselOutput);
      end else begin
        en_d[p] = 1'b0;
      end
    end
  end

  // Pin level view: latch on output pins, external level elsewhere
  assign lv      = (latch_q & en_d) | (st_q.pin_levels_in & ~en_d);
  assign lv_wide = (2*DW)'(lv);

  // Read mux
  always_comb begin
    rd = '0;
    if (!wr) begin
      unique case (st_q.word_offset) inside
        [gpio_rb_pkg::OffSelFirst:gpio_rb_pkg::OffSelLast]: begin
          rd = DW'(fsel_q[st_q.word_offset[2:0]]);
        end
        gpio_rb_pkg::OffLev0:     rd = lv_wide[DW-1:0];
        gpio_rb_pkg::OffLev1:     rd = lv_wide[2*DW-1:DW];
        gpio_rb_pkg::OffPullCode: rd = DW'(pcode_q);
        gpio_rb_pkg::OffPullClk0: rd = pclk_q[0];
        gpio_rb_pkg::OffPullClk1: rd = pclk_q[1];
        default:                  rd = '0;
      endcase
    end
  end

  // Assemble the response beat from the post-access state
  always_comb begin
    res_d.read_data     = rd;
    res_d.drive_levels  = latch_d;
    res_d.drive_enables = en_d;
    for (int p = 0; p < NP; p++) begin
      res_d.pull_up_enables[p]   = (pstate_d[p] == gpio_rb_pkg::PullUp);
      res_d.pull_down_enables[p] = (pstate_d[p] == gpio_rb_pkg::PullDown);
    end
  end

  // Register state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gpio_rb_pkg::SelWords; i++) begin
        fsel_q[i] <= '0;
      end
      latch_q   <= '0;
      pcode_q   <= '0;
      pclk_q[0] <= '0;
      pclk_q[1] <= '0;
      for (int p = 0; p < NP; p++) begin
        pstate_q[p] <= '0;
      end
    end else if (advance) begin
      fsel_q   <= fsel_d;
      latch_q  <= latch_d;
      pcode_q  <= pcode_d;
      pclk_q   <= pclk_d;
      pstate_q <= pstate_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid             = res_valid_q;
  assign rsp_o.read_data         = res_q.read_data;
  assign rsp_o.drive_levels      = res_q.drive_levels;
  assign rsp_o.drive_enables     = res_q.drive_enables;
  assign rsp_o.pull_up_enables   = res_q.pull_up_enables;
  assign rsp_o.pull_down_enables = res_q.pull_down_enables;

  // A pin never pulls both ways
  a_pull_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.pull_up_enables & rsp_o.pull_down_enables) == '0))
    else $error("pull-up and pull-down both enabled on a pin");

  // Writes return a zero read word
  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && st_q.opcode == gpio_rb_pkg::OpWrite) |=> (rsp_o.read_data == '0))
    else $error("write beat returned nonzero read data");

  // Backpressure only when both stages are full and the response is not being taken
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (st_valid_q && res_valid_q && !rsp_o.ready))
    else $error("request stalled with a free stage");

endmodule
`default_nettype wire
